@@ sv/iqcic_pkg.sv @@
// Package for the I/Q CIC decimator: default sizes, sample and result
// constants, configuration register codes and the lane control struct.
// No dependencies; every other file of the block uses it.
package iqcic_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_STAGES_DEF = 4;
    localparam int MAX_RATIO_DEF  = 64;
    localparam int ACC_WIDTH_DEF  = 32;

    // Sample and result width, and the quotient bits below the saturation bit.
    localparam int SAMPLE_W = 8;
    localparam int QUO_W    = SAMPLE_W - 1;
    localparam int BIT_W    = $clog2(QUO_W + 1);

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 8'sd127;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -8'sd128;

    // Configuration registers.
    localparam int RATIO_CFG_W  = 7;
    localparam int STAGES_CFG_W = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = RATIO_CFG_W;

    localparam logic [RATIO_CFG_W-1:0]  RATIO_RESET  = 7'd10;
    localparam logic [STAGES_CFG_W-1:0] STAGES_RESET = 3'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DECIM_RATIO = 2'd0,
        REG_STAGE_COUNT = 2'd1
    } cfg_reg_t;

    // Per-cycle operation for both lanes.
    typedef struct packed {
        logic             load;
        logic             integ;
        logic             comb;
        logic             prep;
        logic             div;
        logic [BIT_W-1:0] bit_idx;
    } lane_ctrl_t;

endpackage

@@ sv/iq_cic_decimator.sv @@
// I/Q CIC decimator. An item without a result takes the input beat and one adder
// step per lane for each of the N integrator stages.
// An item with a result runs N integrator, N comb, one sign and eight divider steps,
// then the output load, which waits while an unread beat holds the output register.
// Reset is asynchronous and clears integrators, combs, the phase counter and
// the output; decim_ratio resets to 10 and stage_count to 3.
module iq_cic_decimator #(
    parameter int MAX_STAGES = iqcic_pkg::MAX_STAGES_DEF,
    parameter int MAX_RATIO  = iqcic_pkg::MAX_RATIO_DEF,
    parameter int ACC_WIDTH  = iqcic_pkg::ACC_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [iqcic_pkg::SAMPLE_W-1:0]  in_i,
    input  logic signed [iqcic_pkg::SAMPLE_W-1:0]  in_q,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [iqcic_pkg::SAMPLE_W-1:0]  out_i,
    output logic signed [iqcic_pkg::SAMPLE_W-1:0]  out_q,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [iqcic_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [iqcic_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int RATIO_W = $clog2(MAX_RATIO + 1);
    localparam int PHASE_W = $clog2(MAX_RATIO);
    localparam int NCNT_W  = $clog2(MAX_STAGES + 1);
    localparam int STAGE_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INTEG,
        S_COMB,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    state_t                                  state_reg;
    logic [STAGE_W-1:0]                      stage_reg;
    logic [iqcic_pkg::BIT_W-1:0]             bit_reg;
    logic                                    emit_reg;
    logic [PHASE_W-1:0]                      phase_reg;
    logic                                    out_valid_reg;
    logic signed [iqcic_pkg::SAMPLE_W-1:0]   out_i_reg;
    logic signed [iqcic_pkg::SAMPLE_W-1:0]   out_q_reg;
    logic [iqcic_pkg::RATIO_CFG_W-1:0]       decim_ratio_reg;
    logic [iqcic_pkg::STAGES_CFG_W-1:0]      stage_count_reg;

    logic [RATIO_W-1:0]                      r_eff;
    logic [NCNT_W-1:0]                       n_eff;
    logic                                    accept;
    logic                                    emit_now;
    logic                                    stage_last;
    logic                                    out_load;
    iqcic_pkg::lane_ctrl_t                   ctrl;
    logic [ACC_WIDTH-1:0]                    gain;
    logic signed [iqcic_pkg::SAMPLE_W-1:0]   res_i;
    logic signed [iqcic_pkg::SAMPLE_W-1:0]   res_q;

    // Effective ratio and stage count after clamping.
    always_comb
    begin
        if (decim_ratio_reg == '0)
            r_eff = RATIO_W'(1);
        else if (int'(decim_ratio_reg) > MAX_RATIO)
            r_eff = RATIO_W'(MAX_RATIO);
        else
            r_eff = RATIO_W'(decim_ratio_reg);

        if (int'(stage_count_reg) > MAX_STAGES)
            n_eff = NCNT_W'(MAX_STAGES);
        else
            n_eff = NCNT_W'(stage_count_reg);
    end

    // Handshake and sequencing conditions.
    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign accept     = in_valid && in_ready;
    assign emit_now   = (RATIO_W'(phase_reg) + RATIO_W'(1)) >= r_eff;
    assign stage_last = (NCNT_W'(stage_reg) + NCNT_W'(1)) == n_eff;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // Lane operation for this cycle.
    always_comb
    begin
        ctrl         = '0;
        ctrl.load    = accept;
        ctrl.integ   = (state_reg == S_INTEG);
        ctrl.comb    = (state_reg == S_COMB);
        ctrl.prep    = (state_reg == S_PREP);
        ctrl.div     = (state_reg == S_DIV);
        ctrl.bit_idx = bit_reg;
    end

    // Gain is built alongside the integrator steps.
    iqcic_gain #(
        .ACC_WIDTH (ACC_WIDTH),
        .RATIO_W   (RATIO_W)
    ) u_gain (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .step  (ctrl.integ),
        .ratio (r_eff),
        .gain  (gain)
    );

    // In-phase and quadrature lanes run in lockstep.
    iqcic_lane #(
        .MAX_STAGES (MAX_STAGES),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_lane_i (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .stage  (stage_reg),
        .sample (in_i),
        .gain   (gain),
        .result (res_i)
    );

    iqcic_lane #(
        .MAX_STAGES (MAX_STAGES),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_lane_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .stage  (stage_reg),
        .sample (in_q),
        .gain   (gain),
        .result (res_q)
    );

    // Sequencer, configuration registers and the merged output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stage_reg       <= '0;
            bit_reg         <= '0;
            emit_reg        <= 1'b0;
            phase_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_i_reg       <= '0;
            out_q_reg       <= '0;
            decim_ratio_reg <= iqcic_pkg::RATIO_RESET;
            stage_count_reg <= iqcic_pkg::STAGES_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    iqcic_pkg::REG_DECIM_RATIO:
                        decim_ratio_reg <= cfg_data[iqcic_pkg::RATIO_CFG_W-1:0];
                    iqcic_pkg::REG_STAGE_COUNT:
                        stage_count_reg <= cfg_data[iqcic_pkg::STAGES_CFG_W-1:0];
                    default:
                        ;
                endcase
            end

            // The output beat drains unless a new result takes its place.
            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        emit_reg  <= emit_now;
                        phase_reg <= emit_now ? '0 : (phase_reg + PHASE_W'(1));
                        stage_reg <= '0;
                        if (n_eff != '0)
                            state_reg <= S_INTEG;
                        else if (emit_now)
                            state_reg <= S_PREP;
                    end
                end
                S_INTEG:
                begin
                    if (stage_last)
                    begin
                        stage_reg <= '0;
                        state_reg <= emit_reg ? S_COMB : S_IDLE;
                    end
                    else
                    begin
                        stage_reg <= stage_reg + STAGE_W'(1);
                    end
                end
                S_COMB:
                begin
                    if (stage_last)
                        state_reg <= S_PREP;
                    else
                        stage_reg <= stage_reg + STAGE_W'(1);
                end
                S_PREP:
                begin
                    bit_reg   <= iqcic_pkg::BIT_W'(iqcic_pkg::QUO_W);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (bit_reg == '0)
                        state_reg <= S_OUT;
                    else
                        bit_reg <= bit_reg - iqcic_pkg::BIT_W'(1);
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_i_reg     <= res_i;
                        out_q_reg     <= res_q;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

    // A finished result always reaches the output register.
    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("finished result did not reach the output register");

    // With integrator stages in use, input is blocked right after a beat.
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (n_eff != '0) |=> !in_ready)
        else $error("input taken again while integrators still running");

    // The last divider step always leads to the output state.
    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (bit_reg == '0) |=> (state_reg == S_OUT))
        else $error("divider did not hand over to the output stage");

endmodule

@@ sv/iqcic_gain.sv @@
// Gain unit: builds ratio^stages one multiply per stage, saturating at the
// all-ones accumulator value. Depends on iqcic_pkg.
module iqcic_gain #(
    parameter int ACC_WIDTH = iqcic_pkg::ACC_WIDTH_DEF,
    parameter int RATIO_W   = $clog2(iqcic_pkg::MAX_RATIO_DEF + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 step,
    input  logic [RATIO_W-1:0]   ratio,
    output logic [ACC_WIDTH-1:0] gain
);

    localparam int PROD_W = ACC_WIDTH + RATIO_W;

    logic [ACC_WIDTH-1:0] gain_reg;
    logic [PROD_W-1:0]    prod;

    // One narrow-by-wide multiply per stage.
    assign prod = PROD_W'(gain_reg) * PROD_W'(ratio);

    // Any gain above the largest magnitude gives a zero quotient, so the
    // clamped value divides the same way as the true one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= ACC_WIDTH'(1);
        end
        else if (start)
        begin
            gain_reg <= ACC_WIDTH'(1);
        end
        else if (step)
        begin
            if (prod[PROD_W-1:ACC_WIDTH] != '0)
                gain_reg <= '1;
            else
                gain_reg <= prod[ACC_WIDTH-1:0];
        end
    end

    assign gain = gain_reg;

endmodule

@@ sv/iqcic_lane.sv @@
// One lane of the decimator: integrator and comb registers, an adder and a subtractor
// that walk the stages, and a restoring divider with saturation.
// Depends on iqcic_pkg.
module iqcic_lane #(
    parameter int  MAX_STAGES = iqcic_pkg::MAX_STAGES_DEF,
    parameter int  ACC_WIDTH  = iqcic_pkg::ACC_WIDTH_DEF,
    localparam int STAGE_W    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  iqcic_pkg::lane_ctrl_t                  ctrl,
    input  logic [STAGE_W-1:0]                     stage,
    input  logic signed [iqcic_pkg::SAMPLE_W-1:0]  sample,
    input  logic [ACC_WIDTH-1:0]                   gain,
    output logic signed [iqcic_pkg::SAMPLE_W-1:0]  result
);

    localparam int DIV_W = ACC_WIDTH + iqcic_pkg::QUO_W;

    logic [ACC_WIDTH-1:0]            integ_reg [MAX_STAGES];
    logic [ACC_WIDTH-1:0]            comb_reg  [MAX_STAGES];
    logic [ACC_WIDTH-1:0]            val_reg;
    logic [ACC_WIDTH-1:0]            rem_reg;
    logic                            neg_reg;
    logic                            sat_reg;
    logic [iqcic_pkg::QUO_W-1:0]     quo_reg;

    logic [ACC_WIDTH-1:0]            integ_sum;
    logic [ACC_WIDTH-1:0]            comb_diff;
    logic [DIV_W-1:0]                shifted;
    logic                            ge;
    logic [iqcic_pkg::SAMPLE_W-1:0]  mag;

    // Stage arithmetic, wrapping at the accumulator width.
    assign integ_sum = integ_reg[stage] + val_reg;
    assign comb_diff = val_reg - comb_reg[stage];

    // Divider trial: remainder against the gain shifted to the current bit.
    assign shifted = DIV_W'(gain) << ctrl.bit_idx;
    assign ge      = (DIV_W'(rem_reg) >= shifted);

    // Integrators, combs and the divider share one sequenced datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_STAGES; s++)
            begin
                integ_reg[s] <= '0;
                comb_reg[s]  <= '0;
            end
            val_reg <= '0;
            rem_reg <= '0;
            neg_reg <= 1'b0;
            sat_reg <= 1'b0;
            quo_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                val_reg <= ACC_WIDTH'(sample);
            end
            if (ctrl.integ)
            begin
                integ_reg[stage] <= integ_sum;
                val_reg          <= integ_sum;
            end
            if (ctrl.comb)
            begin
                comb_reg[stage] <= val_reg;
                val_reg         <= comb_diff;
            end
            // Split into sign and magnitude so the quotient truncates
            // toward zero.
            if (ctrl.prep)
            begin
                neg_reg <= val_reg[ACC_WIDTH-1];
                rem_reg <= val_reg[ACC_WIDTH-1] ? (~val_reg + ACC_WIDTH'(1)) : val_reg;
                quo_reg <= '0;
                sat_reg <= 1'b0;
            end
            // The top trial only decides saturation; the rest build the
            // quotient one bit at a time.
            if (ctrl.div)
            begin
                if (ctrl.bit_idx == iqcic_pkg::BIT_W'(iqcic_pkg::QUO_W))
                begin
                    sat_reg <= ge;
                end
                else
                begin
                    quo_reg <= {quo_reg[iqcic_pkg::QUO_W-2:0], ge};
                    if (ge)
                        rem_reg <= rem_reg - shifted[ACC_WIDTH-1:0];
                end
            end
        end
    end

    // Signed, saturated result of this lane.
    assign mag = {1'b0, quo_reg};

    always_comb
    begin
        if (sat_reg)
            result = neg_reg ? iqcic_pkg::OUT_MIN : iqcic_pkg::OUT_MAX;
        else if (neg_reg)
            result = $signed(-mag);
        else
            result = $signed(mag);
    end

endmodule
